>>> rtl/core/nms_pkg.sv
// Package for the 3x3 neighbour mean smoother: sizes, register indexes,
// neighbour slot codes, divider request type and register clamp helpers.
// Used by nms_div and neighbour_mean_smoother_3x3_top.
package nms_pkg;

  // Frame limits and pixel history depth (two rows plus two pixels)
  localparam int unsigned MaxCols   = 128;
  localparam int unsigned MaxRows   = 1024;
  localparam int unsigned HistDepth = 2 * MaxCols + 2;

  // Field widths
  localparam int unsigned PixW     = 8;
  localparam int unsigned CfgColsW = 8;
  localparam int unsigned CfgRowsW = 11;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned MeanW    = 16;
  localparam int unsigned CntW     = 4;

  // Internal widths
  localparam int unsigned ColW    = $clog2(MaxCols + 1);
  localparam int unsigned RowW    = $clog2(MaxRows + 1);
  localparam int unsigned OutColW = $clog2(MaxCols);
  localparam int unsigned OutRowW = $clog2(MaxRows);
  localparam int unsigned PosW    = $clog2(MaxRows * MaxCols + MaxCols + 1);
  localparam int unsigned AddrW   = $clog2(HistDepth);
  localparam int unsigned DiffW   = AddrW + 1;
  localparam int unsigned NbrN    = 8;
  localparam int unsigned SumW    = $clog2(NbrN * (2 ** PixW - 1) + 1);
  localparam int unsigned FracW   = 8;
  localparam int unsigned NumW    = SumW + FracW + 1;
  localparam int unsigned DenW    = CntW + 1;
  localparam int unsigned StepW   = $clog2(NumW + 1);
  localparam int unsigned SlotW   = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFrameCols = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFrameRows = CfgIdxW'(1);

  // Neighbour slots in history read order; SlotDownRight is the incoming pixel and is not read
  localparam logic [SlotW-1:0] SlotUpLeft    = SlotW'(0);
  localparam logic [SlotW-1:0] SlotUp        = SlotW'(1);
  localparam logic [SlotW-1:0] SlotUpRight   = SlotW'(2);
  localparam logic [SlotW-1:0] SlotLeft      = SlotW'(3);
  localparam logic [SlotW-1:0] SlotRight     = SlotW'(4);
  localparam logic [SlotW-1:0] SlotDownLeft  = SlotW'(5);
  localparam logic [SlotW-1:0] SlotDown      = SlotW'(6);
  localparam logic [SlotW-1:0] SlotDownRight = SlotW'(7);

  // Divider request: numerator and divisor
  typedef struct packed {
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  // Map a raw column count onto 1..MaxCols
  function automatic logic [ColW-1:0] clamp_cols(input logic [CfgColsW-1:0] v);
    logic [ColW-1:0] r;
    if (v == '0) begin
      r = ColW'(1);
    end else if (int'(v) > int'(MaxCols)) begin
      r = ColW'(MaxCols);
    end else begin
      r = ColW'(v);
    end
    return r;
  endfunction

  // Map a raw row count onto 1..MaxRows
  function automatic logic [RowW-1:0] clamp_rows(input logic [CfgRowsW-1:0] v);
    logic [RowW-1:0] r;
    if (v == '0) begin
      r = RowW'(1);
    end else if (int'(v) > int'(MaxRows)) begin
      r = RowW'(MaxRows);
    end else begin
      r = RowW'(v);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/nms_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No package dependency.
module nms_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/nms_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nms_pkg for widths and the request type.
module nms_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  nms_pkg::div_req_t       req_i,
  output logic                    done_o,
  output logic [nms_pkg::MeanW-1:0] quot_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [nms_pkg::StepW-1:0]   step_q;
  logic [nms_pkg::NumW-1:0]    acc_q;
  logic [nms_pkg::DenW-1:0]    rem_q;
  logic [nms_pkg::DenW-1:0]    den_q;
  logic [nms_pkg::DenW:0]      rem_sh;
  logic                        ge;
  logic [nms_pkg::DenW-1:0]    rem_d;

  // Shift in the next numerator bit and trial-subtract the divisor
  always_comb begin
    rem_sh = {rem_q, acc_q[nms_pkg::NumW-1]};
    ge     = rem_sh >= {1'b0, den_q};
    if (ge) begin
      rem_d = nms_pkg::DenW'(rem_sh - {1'b0, den_q});
    end else begin
      rem_d = rem_sh[nms_pkg::DenW-1:0];
    end
  end

  // Control: step count and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + nms_pkg::StepW'(1);
        if (step_q == nms_pkg::StepW'(nms_pkg::NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift into the numerator register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[nms_pkg::NumW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q[nms_pkg::MeanW-1:0];

endmodule

>>> rtl/core/neighbour_mean_smoother_3x3_top.sv
// Flow: an item that yields no result (the first cols+1 items of a frame)
// is written to the history, if inside the frame, as it is accepted. An
// item that yields a result is accepted, its neighbours are read one after
// another through the single read port of the pixel history RAM, the sum
// is finished, the bit-serial divider produces its 20 quotient bits and
// signals done, and the output word is loaded; the divider is skipped when
// the position has no neighbours. A result word still waiting at the output holds the load.
// Results lag the pixels by cols+1 items; send cols+1 drain words after each
// frame to flush it. A configuration write restarts the frame. The history
// RAM needs no clearing after reset. Built on nms_pkg, nms_ram and nms_div.
module neighbour_mean_smoother_3x3_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [nms_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [nms_pkg::CfgDataW-1:0]  cfg_data_i,
  // Pixel stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] pixel
  input  logic                          s_axis_tuser,  // [0] drain
  // Result stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // [15:0] mean_value,
                                                       // [19:16] neighbour_count
  output logic                          m_axis_tlast   // last_of_frame
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StRead = 5'b00010,
    StSum  = 5'b00100,
    StDiv  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Frame geometry
  logic [nms_pkg::ColW-1:0]    cols_q;
  logic [nms_pkg::RowW-1:0]    rows_q;
  logic [nms_pkg::PosW-1:0]    total_q;
  logic [nms_pkg::ColW-1:0]    cols_new;
  logic [nms_pkg::RowW-1:0]    rows_new;

  // Position counters
  logic [nms_pkg::PosW-1:0]    pos_q, pos_d;
  logic [nms_pkg::AddrW-1:0]   wr_addr_q, wr_addr_d;
  logic [nms_pkg::OutRowW-1:0] row_q, row_d;
  logic [nms_pkg::OutColW-1:0] col_q, col_d;

  // Per-item work registers
  logic [nms_pkg::PixW-1:0]    val_q, val_d;
  logic [nms_pkg::NbrN-1:0]    mask_q, mask_d;
  logic [nms_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [nms_pkg::SumW-1:0]    sum_q, sum_d;
  logic [nms_pkg::SlotW-1:0]   slot_q, slot_d;
  logic                        wr_ok_q, wr_ok_d;
  logic                        last_q, last_d;
  logic                        rd_pend_q, rd_pend_d;
  logic                        rd_mask_q, rd_mask_d;
  logic [nms_pkg::MeanW-1:0]   mean_q, mean_d;

  // Output register
  logic                        out_valid_q, out_valid_d;
  logic [nms_pkg::MeanW-1:0]   out_mean_q;
  logic [nms_pkg::CntW-1:0]    out_cnt_q;
  logic                        out_last_q;
  logic                        out_load;

  // Item decode
  logic                        accept;
  logic                        emit;
  logic                        in_frame;
  logic                        at_last;
  logic                        has_up, has_dn, has_lf, has_rt;
  logic [nms_pkg::NbrN-1:0]    mask_now;
  logic [nms_pkg::PixW-1:0]    val_in;
  logic [nms_pkg::PixW-1:0]    rd_add;

  // History RAM access
  logic                        mem_we;
  logic [nms_pkg::PixW-1:0]    mem_wdata;
  logic [nms_pkg::AddrW-1:0]   mem_raddr;
  logic [nms_pkg::PixW-1:0]    mem_rdata;
  logic [nms_pkg::DiffW-1:0]   slot_dist;
  logic [nms_pkg::DiffW-1:0]   diff;

  // Divider
  logic                        div_start;
  nms_pkg::div_req_t           div_req;
  logic                        div_done;
  logic [nms_pkg::MeanW-1:0]   div_quot;

  // Clamp incoming register values
  always_comb begin
    cols_new = cols_q;
    rows_new = rows_q;
    if (cfg_idx_i == nms_pkg::CfgFrameCols) begin
      cols_new = nms_pkg::clamp_cols(cfg_data_i[nms_pkg::CfgColsW-1:0]);
    end
    if (cfg_idx_i == nms_pkg::CfgFrameRows) begin
      rows_new = nms_pkg::clamp_rows(cfg_data_i[nms_pkg::CfgRowsW-1:0]);
    end
  end

  // Hold frame geometry, recompute the frame size on a write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= nms_pkg::ColW'(nms_pkg::MaxCols);
      rows_q  <= nms_pkg::RowW'(nms_pkg::MaxRows);
      total_q <= nms_pkg::PosW'(nms_pkg::MaxRows * nms_pkg::MaxCols);
    end else if (cfg_we_i) begin
      cols_q  <= cols_new;
      rows_q  <= rows_new;
      total_q <= nms_pkg::PosW'(nms_pkg::PosW'(rows_new) * nms_pkg::PosW'(cols_new));
    end
  end

  // Decode the position whose result is due
  always_comb begin
    val_in   = s_axis_tuser ? '0 : s_axis_tdata[nms_pkg::PixW-1:0];
    emit     = pos_q >= (nms_pkg::PosW'(cols_q) + nms_pkg::PosW'(1));
    in_frame = pos_q < total_q;
    at_last  = pos_q >= (total_q + nms_pkg::PosW'(cols_q));
    has_up   = row_q != '0;
    has_dn   = (nms_pkg::RowW'(row_q) + nms_pkg::RowW'(1)) < rows_q;
    has_lf   = col_q != '0;
    has_rt   = (nms_pkg::ColW'(col_q) + nms_pkg::ColW'(1)) < cols_q;
    mask_now = '0;
    mask_now[nms_pkg::SlotUpLeft]    = has_up & has_lf;
    mask_now[nms_pkg::SlotUp]        = has_up;
    mask_now[nms_pkg::SlotUpRight]   = has_up & has_rt;
    mask_now[nms_pkg::SlotLeft]      = has_lf;
    mask_now[nms_pkg::SlotRight]     = has_rt;
    mask_now[nms_pkg::SlotDownLeft]  = has_dn & has_lf;
    mask_now[nms_pkg::SlotDown]      = has_dn;
    mask_now[nms_pkg::SlotDownRight] = has_dn & has_rt;
  end

  // Distance back from the current position for each neighbour slot
  always_comb begin
    unique case (slot_q)
      nms_pkg::SlotUpLeft:   slot_dist = (nms_pkg::DiffW'(cols_q) << 1) + nms_pkg::DiffW'(2);
      nms_pkg::SlotUp:       slot_dist = (nms_pkg::DiffW'(cols_q) << 1) + nms_pkg::DiffW'(1);
      nms_pkg::SlotUpRight:  slot_dist = nms_pkg::DiffW'(cols_q) << 1;
      nms_pkg::SlotLeft:     slot_dist = nms_pkg::DiffW'(cols_q) + nms_pkg::DiffW'(2);
      nms_pkg::SlotRight:    slot_dist = nms_pkg::DiffW'(cols_q);
      nms_pkg::SlotDownLeft: slot_dist = nms_pkg::DiffW'(2);
      nms_pkg::SlotDown:     slot_dist = nms_pkg::DiffW'(1);
      default:               slot_dist = '0;
    endcase
    diff = {1'b0, wr_addr_q} - slot_dist;
    if (diff[nms_pkg::DiffW-1]) begin
      mem_raddr = nms_pkg::AddrW'(diff + nms_pkg::DiffW'(nms_pkg::HistDepth));
    end else begin
      mem_raddr = diff[nms_pkg::AddrW-1:0];
    end
  end

  assign rd_add = (rd_pend_q && rd_mask_q) ? mem_rdata : '0;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    wr_addr_d   = wr_addr_q;
    row_d       = row_q;
    col_d       = col_q;
    val_d       = val_q;
    mask_d      = mask_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    slot_d      = slot_q;
    wr_ok_d     = wr_ok_q;
    last_d      = last_q;
    rd_pend_d   = 1'b0;
    rd_mask_d   = 1'b0;
    mean_d      = mean_q;
    mem_we      = 1'b0;
    mem_wdata   = val_q;
    div_start   = 1'b0;
    div_req.num = (nms_pkg::NumW'(sum_d) << (nms_pkg::FracW + 1)) + nms_pkg::NumW'(cnt_q);
    div_req.den = {cnt_q, 1'b0};
    out_load    = 1'b0;
    accept      = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          accept  = 1'b1;
          val_d   = val_in;
          mask_d  = mask_now;
          cnt_d   = nms_pkg::CntW'($countones(mask_now));
          wr_ok_d = in_frame;
          last_d  = at_last;
          if (emit) begin
            sum_d   = mask_now[nms_pkg::SlotDownRight] ? nms_pkg::SumW'(val_in) : '0;
            slot_d  = nms_pkg::SlotUpLeft;
            state_d = StRead;
          end else begin
            // No result yet: store the pixel and advance
            mem_we    = in_frame;
            mem_wdata = val_in;
            pos_d     = pos_q + nms_pkg::PosW'(1);
            wr_addr_d = (wr_addr_q == nms_pkg::AddrW'(nms_pkg::HistDepth - 1)) ? '0 :
                        wr_addr_q + nms_pkg::AddrW'(1);
          end
        end
      end
      StRead: begin
        // Issue one history read per cycle, add the previous one
        sum_d     = sum_q + nms_pkg::SumW'(rd_add);
        rd_pend_d = 1'b1;
        rd_mask_d = mask_q[slot_q];
        slot_d    = slot_q + nms_pkg::SlotW'(1);
        if (slot_q == nms_pkg::SlotDown) begin
          state_d = StSum;
        end
      end
      StSum: begin
        // Add the last read and hand the full sum to the divider
        sum_d       = sum_q + nms_pkg::SumW'(rd_add);
        div_req.num = (nms_pkg::NumW'(sum_d) << (nms_pkg::FracW + 1)) +
                      nms_pkg::NumW'(cnt_q);
        if (cnt_q == '0) begin
          mean_d  = '0;
          state_d = StOut;
        end else begin
          div_start = 1'b1;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          mean_d  = div_quot;
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          mem_we   = wr_ok_q;
          state_d  = StIdle;
          if (last_q) begin
            // Frame done: restart all counters
            pos_d     = '0;
            wr_addr_d = '0;
            row_d     = '0;
            col_d     = '0;
          end else begin
            pos_d     = pos_q + nms_pkg::PosW'(1);
            wr_addr_d = (wr_addr_q == nms_pkg::AddrW'(nms_pkg::HistDepth - 1)) ? '0 :
                        wr_addr_q + nms_pkg::AddrW'(1);
            if ((nms_pkg::ColW'(col_q) + nms_pkg::ColW'(1)) >= cols_q) begin
              col_d = '0;
              row_d = row_q + nms_pkg::OutRowW'(1);
            end else begin
              col_d = col_q + nms_pkg::OutColW'(1);
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register: take a new word when empty or being drained
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pos_q       <= '0;
      wr_addr_q   <= '0;
      row_q       <= '0;
      col_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        pos_q     <= '0;
        wr_addr_q <= '0;
        row_q     <= '0;
        col_q     <= '0;
      end else begin
        pos_q     <= pos_d;
        wr_addr_q <= wr_addr_d;
        row_q     <= row_d;
        col_q     <= col_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    mask_q    <= mask_d;
    cnt_q     <= cnt_d;
    sum_q     <= sum_d;
    slot_q    <= slot_d;
    wr_ok_q   <= wr_ok_d;
    last_q    <= last_d;
    rd_mask_q <= rd_mask_d;
    mean_q    <= mean_d;
    if (out_load) begin
      out_mean_q <= mean_q;
      out_cnt_q  <= cnt_q;
      out_last_q <= last_q;
    end
  end

  nms_ram #(
    .Width (nms_pkg::PixW),
    .Depth (nms_pkg::HistDepth)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_addr_q),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  nms_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_cnt_q, out_mean_q};
  assign m_axis_tlast  = out_last_q;

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready))
    else $error("result word overwritten");

  // Divider finishes only while the sequencer waits for it
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv))
    else $error("divider done outside divide phase");

  // History write pointer, tracking the position modulo the history depth, stays below that depth
  a_wr_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_addr_q < nms_pkg::AddrW'(nms_pkg::HistDepth))
    else $error("history pointer out of range");

  // Output column stays inside the frame
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(accept) |-> (nms_pkg::ColW'(col_q) < cols_q))
    else $error("output column beyond frame width");

endmodule
